/* rtl/srg_pkg.sv */
package srg_pkg;

    localparam int unsigned VAL_W  = 30;
    localparam int unsigned SEED_W = 31;
    localparam int unsigned LEN    = 55;
    localparam int unsigned LAG    = 31;
    localparam int unsigned SCAT   = 21;
    localparam int unsigned PTR_W  = 6;
    localparam int unsigned CNT_W  = 8;

    // four warm-up passes over the whole table
    localparam int unsigned WARM_STEPS = 4 * LEN;

    localparam logic [VAL_W-1:0]  MOD   = VAL_W'(1000000000);
    localparam logic [SEED_W-1:0] MAGIC = SEED_W'(161803398);

    typedef struct packed {
        logic seed_load;
        logic seed_reduce;
        logic scatter_step;
        logic ptr_init;
        logic issue;
        logic wr_step;
        logic load_out;
    } t_cmd;

    // a - b modulo 10^9, both operands below the modulus
    function automatic logic [VAL_W-1:0] sub_mod(
        input logic [VAL_W-1:0] a,
        input logic [VAL_W-1:0] b
    );
        logic [VAL_W:0] diff;
        diff = {1'b0, a} - {1'b0, b};
        if (diff[VAL_W]) begin
            sub_mod = diff[VAL_W-1:0] + MOD;
        end else begin
            sub_mod = diff[VAL_W-1:0];
        end
    endfunction

    // cyclic pointer over positions 1..55
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        if (p >= PTR_W'(LEN)) begin
            advance = PTR_W'(1);
        end else begin
            advance = p + PTR_W'(1);
        end
    endfunction

endpackage

/* rtl/srg_ram.sv */
module srg_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 55
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* rtl/srg_datapath.sv */
module srg_datapath
    import srg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [SEED_W-1:0] i_seed_magnitude,
    output logic [VAL_W-1:0]  o_random_value
);

    logic [SEED_W-1:0] r_abs;
    logic [VAL_W-1:0]  r_cur;
    logic [VAL_W-1:0]  r_nxt;
    logic [PTR_W-1:0]  r_pos;
    logic [PTR_W-1:0]  r_draw;
    logic [PTR_W-1:0]  r_lag;
    logic [VAL_W-1:0]  r_out;

    logic [SEED_W:0]   seed_diff;
    logic [SEED_W-1:0] seed_abs;
    logic [VAL_W-1:0]  seed_red;
    logic [PTR_W:0]    pos_sum;
    logic [PTR_W-1:0]  pos_next;
    logic [PTR_W-1:0]  draw_next;
    logic [PTR_W-1:0]  lag_next;
    logic [VAL_W-1:0]  rd_a;
    logic [VAL_W-1:0]  rd_b;
    logic [VAL_W-1:0]  step_val;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [VAL_W-1:0]  wr_data;

    // |magic - seed|, always below twice the modulus
    assign seed_diff = {1'b0, MAGIC} - {1'b0, i_seed_magnitude};
    assign seed_abs  = seed_diff[SEED_W] ? SEED_W'(-seed_diff) : seed_diff[SEED_W-1:0];
    assign seed_red  = (r_abs >= SEED_W'(MOD)) ? VAL_W'(r_abs - SEED_W'(MOD))
                                               : r_abs[VAL_W-1:0];

    // scatter position steps by 21 modulo 55, zero shown as 55
    assign pos_sum  = {1'b0, r_pos} + (PTR_W+1)'(SCAT);
    assign pos_next = (pos_sum > (PTR_W+1)'(LEN)) ? PTR_W'(pos_sum - (PTR_W+1)'(LEN))
                                                  : pos_sum[PTR_W-1:0];

    assign draw_next = advance(r_draw);
    assign lag_next  = advance(r_lag);
    assign step_val  = sub_mod(rd_a, rd_b);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_draw - PTR_W'(1);
        wr_data = step_val;
        if (i_cmd.seed_reduce) begin
            wr_en   = 1'b1;
            wr_addr = PTR_W'(LEN - 1);
            wr_data = seed_red;
        end else if (i_cmd.scatter_step) begin
            wr_en   = 1'b1;
            wr_addr = r_pos - PTR_W'(1);
            wr_data = r_nxt;
        end else if (i_cmd.wr_step) begin
            wr_en   = 1'b1;
        end
    end

    srg_ram #(
        .WIDTH (VAL_W),
        .DEPTH (LEN)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (i_cmd.issue),
        .i_rd_addr_a (draw_next - PTR_W'(1)),
        .i_rd_addr_b (lag_next - PTR_W'(1)),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw <= '0;
            r_lag  <= PTR_W'(LAG);
        end else if (i_cmd.ptr_init) begin
            r_draw <= '0;
            r_lag  <= PTR_W'(LAG);
        end else if (i_cmd.issue) begin
            r_draw <= draw_next;
            r_lag  <= lag_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_abs <= seed_abs;
        end
        if (i_cmd.seed_reduce) begin
            r_cur <= seed_red;
            r_nxt <= VAL_W'(1);
            r_pos <= PTR_W'(SCAT);
        end else if (i_cmd.scatter_step) begin
            r_cur <= r_nxt;
            r_nxt <= sub_mod(r_cur, r_nxt);
            r_pos <= pos_next;
        end
        if (i_cmd.load_out) begin
            r_out <= step_val;
        end
    end

    assign o_random_value = r_out;

endmodule

/* rtl/srg_ctrl.sv */
module srg_ctrl
    import srg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_reseed,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_SCATTER,
        S_WARM,
        S_DRAW
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_table_ready;
    logic             r_out_valid;

    logic accept;
    logic need_fill;
    logic out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign need_fill  = i_reseed || !r_table_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.seed_load = accept && need_fill;
                o_cmd.issue     = accept && !need_fill;
            end
            S_SEED: begin
                o_cmd.seed_reduce = 1'b1;
                o_cmd.ptr_init    = 1'b1;
            end
            S_SCATTER: begin
                o_cmd.scatter_step = 1'b1;
            end
            S_WARM: begin
                o_cmd.issue   = 1'b1;
                o_cmd.wr_step = (r_cnt != '0);
            end
            S_DRAW: begin
                o_cmd.wr_step  = out_free;
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_table_ready <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= need_fill ? S_SEED : S_DRAW;
                    end
                end
                S_SEED: begin
                    r_table_ready <= 1'b1;
                    r_cnt         <= '0;
                    r_state       <= S_SCATTER;
                end
                S_SCATTER: begin
                    if (r_cnt == CNT_W'(LEN - 2)) begin
                        r_cnt   <= '0;
                        r_state <= S_WARM;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_WARM: begin
                    if (r_cnt == CNT_W'(WARM_STEPS)) begin
                        r_cnt   <= '0;
                        r_state <= S_DRAW;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DRAW: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/subtractive_random_generator.sv */
// plain draw: the transaction issues a registered read of the 55-word lag table; the
// result is written back and into the output register once that is free, and only then
// is a new request taken; fill (reseed, or first after reset): 1 seed reduce, 54 scatter
// writes, 221 pipelined table steps, 1 output write
// i_rst_n is synchronous, active low: clears the controller, the pointers and table_ready;
// the table itself is not cleared and is always filled before its first read
module subtractive_random_generator
    import srg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_reseed,
    input  logic [SEED_W-1:0] i_seed_magnitude,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [VAL_W-1:0]  o_random_value
);

    // command bundle from the sequencer to the table datapath
    t_cmd cmd;

    // sequencer: handshakes, fill sequence, output register valid
    srg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_reseed    (i_reseed),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // table, pointers, seed arithmetic and the result register;
    // warm-up passes reuse the draw pointers, so the fill ends with an ordinary draw
    srg_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_seed_magnitude (i_seed_magnitude),
        .o_random_value   (o_random_value)
    );

endmodule

/* verif/subtractive_random_generator_tb.sv */
`timescale 1ns / 100ps

import srg_pkg::*;

// tracks the lag table alongside the block and keeps the draws still owed by it
class draw_tracker;

    logic [VAL_W-1:0] lags [1:LEN];
    logic [PTR_W-1:0] draw_pos;
    logic [PTR_W-1:0] lagged_pos;
    bit               filled;
    logic [VAL_W-1:0] owed_draws [$];
    int unsigned      failures;

    function new();
        draw_pos   = '0;
        lagged_pos = PTR_W'(LAG);
        filled     = 1'b0;
        failures   = 0;
    endfunction

    // difference modulo 10^9, operands already reduced
    function logic [VAL_W-1:0] mod_diff(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        logic [VAL_W:0] wide;
        wide = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + {1'b0, MOD} - {1'b0, b};
        return wide[VAL_W-1:0];
    endfunction

    function void refill(logic [SEED_W-1:0] seed);
        longint           start;
        logic [VAL_W-1:0] cur;
        logic [VAL_W-1:0] nxt;
        int               pos;
        int               i;
        int               pass;
        start = longint'(MAGIC) - longint'(seed);
        if (start < 0) begin
            start = -start;
        end
        cur       = VAL_W'(start % longint'(MOD));
        lags[LEN] = cur;
        nxt       = VAL_W'(1);
        // scatter at 21*i mod 55, never zero since 21 and 55 are coprime
        for (i = 1; i < LEN; i++) begin
            pos       = (SCAT * i) % LEN;
            lags[pos] = nxt;
            nxt       = mod_diff(cur, nxt);
            cur       = lags[pos];
        end
        for (pass = 0; pass < 4; pass++) begin
            for (i = 1; i <= LEN; i++) begin
                lags[i] = mod_diff(lags[i], lags[1 + (i + LAG - 1) % LEN]);
            end
        end
        draw_pos   = '0;
        lagged_pos = PTR_W'(LAG);
        filled     = 1'b1;
    endfunction

    function void note_request(bit reseed, logic [SEED_W-1:0] seed);
        logic [VAL_W-1:0] value;
        if (reseed || !filled) begin
            refill(seed);
        end
        draw_pos   = (draw_pos >= PTR_W'(LEN)) ? PTR_W'(1) : draw_pos + PTR_W'(1);
        lagged_pos = (lagged_pos >= PTR_W'(LEN)) ? PTR_W'(1) : lagged_pos + PTR_W'(1);
        value          = mod_diff(lags[draw_pos], lags[lagged_pos]);
        lags[draw_pos] = value;
        owed_draws.push_back(value);
    endfunction

    function void check_draw(logic [VAL_W-1:0] actual);
        logic [VAL_W-1:0] wanted;
        if (owed_draws.size() == 0) begin
            $error("random_value: expected none, actual %0d", actual);
            failures++;
        end else begin
            wanted = owed_draws.pop_front();
            if (actual !== wanted) begin
                $error("random_value: expected %0d, actual %0d", wanted, actual);
                failures++;
            end
        end
    endfunction

    function int unsigned pending();
        return owed_draws.size();
    endfunction

endclass

module subtractive_random_generator_tb;

    // random part of the stimulus, in transactions
    localparam int unsigned RANDOM_ITEMS = 1150;
    // a plain draw answers through the table read and the output register, so a short drain is plenty
    localparam int unsigned DRAIN_CYCLES = 32;
    // slowest run: every transaction reseeding, long sender gaps and receiver stalls,
    // for roughly 1200 transactions, taken a few times over
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;

    // receiver behaviour, switched at random intervals
    typedef enum int unsigned {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY
    } t_rx_mode;

    logic              i_clk;
    logic              i_rst_n          = 1'b0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_ready;
    logic              i_reseed         = 1'b0;
    logic [SEED_W-1:0] i_seed_magnitude = '0;
    logic              o_out_valid;
    logic              i_out_ready      = 1'b0;
    logic [VAL_W-1:0]  o_random_value;

    draw_tracker tracker = new();

    t_rx_mode    rx_mode   = RX_OPEN;
    int unsigned rx_left   = 0;
    int unsigned cycle_cnt = 0;

    subtractive_random_generator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_reseed         (i_reseed),
        .i_seed_magnitude (i_seed_magnitude),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_random_value   (o_random_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // present one request and hold it until the transaction completes
    task automatic send_request(input bit reseed, input logic [SEED_W-1:0] seed);
        i_in_valid       <= 1'b1;
        i_reseed         <= reseed;
        i_seed_magnitude <= seed;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // drop valid for a number of cycles; only called with a non-zero gap
    task automatic pause_sender(input int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // receiver: ready pattern changes character every so often, including long open stretches
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN: begin
                i_out_ready <= 1'b1;
            end
            RX_LIGHT: begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end
            RX_HALF: begin
                i_out_ready <= ($urandom_range(0, 1) != 0);
            end
            default: begin
                i_out_ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    // monitor: requests feed the tracker, results are checked against it in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tracker.note_request(i_reseed, i_seed_magnitude);
            end
            if (o_out_valid && i_out_ready) begin
                tracker.check_draw(o_random_value);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL subtractive_random_generator");
            $finish;
        end
    end

    initial begin
        int unsigned       sent;
        int unsigned       burst_len;
        bit                reseed;
        logic [SEED_W-1:0] seed;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first transaction after reset fills the table even without reseed
        send_request(1'b0, SEED_W'(12345));
        send_request(1'b0, '0);
        send_request(1'b0, '1);
        send_request(1'b0, SEED_W'(777));
        // seed extremes
        send_request(1'b1, '0);
        send_request(1'b0, SEED_W'(98765));
        send_request(1'b1, '1);
        send_request(1'b0, '0);
        // start value of zero: seed equal to the magic constant, and one modulus above it
        send_request(1'b1, MAGIC);
        send_request(1'b0, '1);
        send_request(1'b0, '0);
        send_request(1'b1, MAGIC + SEED_W'(1000000000));
        send_request(1'b0, '0);
        // either side of the magic constant, so the start value flips sign
        send_request(1'b1, MAGIC - SEED_W'(1));
        send_request(1'b1, MAGIC + SEED_W'(1));
        send_request(1'b0, SEED_W'(1));
        send_request(1'b1, SEED_W'(1));
        send_request(1'b1, SEED_W'(1000000000));
        pause_sender(3);
        // reseed straight after a gap, then two draws and a reseed with the seed bits toggling
        send_request(1'b1, SEED_W'(31'h5555_5555));
        send_request(1'b0, SEED_W'(31'h2AAA_AAAA));
        send_request(1'b0, SEED_W'(31'h5555_5555));
        send_request(1'b1, SEED_W'(31'h2AAA_AAAA));
        pause_sender(1);

        // random part: bursts of mostly plain draws, an occasional reseed, so runs of
        // well over 55 draws go through the pointer wrap many times
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(1, 48);
            repeat (burst_len) begin
                reseed = ($urandom_range(0, 31) == 0);
                case ($urandom_range(0, 7))
                    0: begin
                        seed = MAGIC + SEED_W'($urandom_range(0, 8)) - SEED_W'(4);
                    end
                    1: begin
                        seed = SEED_W'($urandom_range(0, 1000));
                    end
                    2: begin
                        seed = '1 - SEED_W'($urandom_range(0, 1000));
                    end
                    3: begin
                        seed = MAGIC + SEED_W'(1000000000) + SEED_W'($urandom_range(0, 4))
                            - SEED_W'(2);
                    end
                    default: begin
                        seed = SEED_W'($urandom());
                    end
                endcase
                send_request(reseed, seed);
                sent++;
            end
            // gaps between bursts, now and then a long one, sometimes none at all
            case ($urandom_range(0, 5))
                0: begin
                end
                1: begin
                    pause_sender($urandom_range(15, 40));
                end
                default: begin
                    pause_sender($urandom_range(1, 6));
                end
            endcase
        end
        i_in_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.failures == 0) begin
            $display("PASS subtractive_random_generator");
        end else begin
            $display("FAIL subtractive_random_generator");
        end
        $finish;
    end

endmodule
